[rtl/ctts_pkg.sv]
`default_nettype none

package ctts_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 32;
  localparam logic [63:0] TICK_PERIOD_RST = 64'd1000000;

  // command codes
  localparam logic [2:0] CMD_TICK         = 3'd0;
  localparam logic [2:0] CMD_REGISTER     = 3'd1;
  localparam logic [2:0] CMD_UNREGISTER   = 3'd2;
  localparam logic [2:0] CMD_SET_PERIODIC = 3'd3;
  localparam logic [2:0] CMD_SET_ONESHOT  = 3'd4;
  localparam logic [2:0] CMD_ENABLE       = 3'd5;
  localparam logic [2:0] CMD_DISABLE      = 3'd6;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] now;
    logic [63:0] amount;
    logic [4:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  slot_taken;
    logic [31:0] fired_mask;
    logic        tick_taken;
    logic [5:0]  used_slots;
    logic [31:0] ticks_so_far;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_SCAN,
    S_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic walk;
    logic scan;
    logic load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_start;
    logic scan_start;
    logic walk_done;
    logic scan_end;
    logic found;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/ctts_ram.sv]
`default_nettype none

module ctts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/ctts_ctrl.sv]
`default_nettype none

module ctts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ctts_pkg::stat_t stat_i,
  output ctts_pkg::ctrl_t      ctrl_o
);

  import ctts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.walk_start) begin
          state_d = S_WALK;
        end else if (stat_i.scan_start) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) state_d = S_FIN;
      end
      S_SCAN: begin
        if (stat_i.found || stat_i.scan_end) state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o       = 1'b1;
        ctrl_o.load_item = in_valid_i;
      end
      S_EXEC: ctrl_o.exec = 1'b1;
      S_WALK: ctrl_o.walk = 1'b1;
      S_SCAN: ctrl_o.scan = 1'b1;
      S_FIN:  ctrl_o.load_out = stat_i.out_free;
      default: ctrl_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ctts_dp.sv]
`default_nettype none

module ctts_dp #(
  parameter int unsigned NUM_SLOTS = ctts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctts_pkg::in_item_t  in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [63:0]         cfg_wdata_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output ctts_pkg::out_item_t      out_data_o,
  input  wire ctts_pkg::ctrl_t     ctrl_i,
  output ctts_pkg::stat_t          stat_o
);

  import ctts_pkg::*;

  localparam int unsigned SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned UCW = $clog2(NUM_SLOTS + 1);

  in_item_t       item_q, item_d;
  logic [63:0]    period_q, period_d;
  logic           timer_on_q, timer_on_d;
  logic [63:0]    compare_q, compare_d;
  logic [31:0]    tick_total_q, tick_total_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [UCW-1:0] count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           status_q, status_d;
  logic [SW-1:0]  taken_q, taken_d;
  logic [NUM_SLOTS-1:0] fired_q, fired_d;
  logic           ticked_q, ticked_d;
  out_item_t      out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [63:0]    due_rd, int_rd;
  logic [63:0]    slot_sum, cmp_sum;
  logic [CW-1:0]  proc_full;
  logic [SW-1:0]  scan_idx, proc_idx, sel_idx, due_waddr;
  logic           tick_match, sel_ok, fire, found, due_we, int_we;

  assign scan_idx  = idx_q[SW-1:0];
  assign proc_full = idx_q - CW'(1);
  assign proc_idx  = proc_full[SW-1:0];
  assign sel_idx   = item_q.slot_select[SW-1:0];
  assign sel_ok    = (int'(item_q.slot_select) < int'(NUM_SLOTS));

  assign tick_match = timer_on_q && (item_q.now >= compare_q);
  assign found      = !used_q[scan_idx];
  assign fire       = used_q[proc_idx] && (item_q.now >= due_rd);

  // one adder for slot deadlines, one for the compare point
  assign slot_sum = item_q.now + (ctrl_i.scan ? item_q.amount : int_rd);
  assign cmp_sum  = item_q.now +
                    ((item_q.command == CMD_SET_PERIODIC) ? item_q.amount : period_q);

  assign int_we    = ctrl_i.scan && found;
  assign due_we    = int_we || (ctrl_i.walk && (idx_q != '0) && fire);
  assign due_waddr = ctrl_i.scan ? scan_idx : proc_idx;

  ctts_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_due_ram (
    .clk_i   (clk_i),
    .we_i    (due_we),
    .waddr_i (due_waddr),
    .wdata_i (slot_sum),
    .raddr_i (scan_idx),
    .rdata_o (due_rd)
  );

  ctts_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_int_ram (
    .clk_i   (clk_i),
    .we_i    (int_we),
    .waddr_i (scan_idx),
    .wdata_i (item_q.amount),
    .raddr_i (scan_idx),
    .rdata_o (int_rd)
  );

  always_comb begin
    item_d       = ctrl_i.load_item ? in_data_i : item_q;
    period_d     = cfg_we_i ? cfg_wdata_i : period_q;
    timer_on_d   = timer_on_q;
    compare_d    = compare_q;
    tick_total_d = tick_total_q;
    used_d       = used_q;
    count_d      = count_q;
    idx_d        = idx_q;
    status_d     = status_q;
    taken_d      = taken_q;
    fired_d      = fired_q;
    ticked_d     = ticked_q;

    if (ctrl_i.exec) begin
      idx_d    = '0;
      status_d = STATUS_OK;
      taken_d  = '0;
      fired_d  = '0;
      ticked_d = 1'b0;
      case (item_q.command)
        CMD_TICK: begin
          if (tick_match) begin
            tick_total_d = tick_total_q + 32'd1;
            compare_d    = cmp_sum;
            ticked_d     = 1'b1;
          end
        end
        CMD_REGISTER: status_d = STATUS_REJECT;  // cleared when the scan finds a slot
        CMD_UNREGISTER: begin
          if (sel_ok && used_q[sel_idx]) begin
            used_d[sel_idx] = 1'b0;
            count_d         = count_q - UCW'(1);
          end else begin
            status_d = STATUS_REJECT;
          end
        end
        CMD_SET_PERIODIC: begin
          if (item_q.amount == '0) begin
            status_d = STATUS_REJECT;
          end else begin
            compare_d  = cmp_sum;
            timer_on_d = 1'b1;
          end
        end
        CMD_SET_ONESHOT: begin
          compare_d  = item_q.amount;
          timer_on_d = 1'b1;
        end
        CMD_ENABLE: begin
          compare_d  = cmp_sum;
          timer_on_d = 1'b1;
        end
        CMD_DISABLE: timer_on_d = 1'b0;
        default: status_d = STATUS_REJECT;
      endcase
    end

    // read of slot idx is in flight while slot idx-1 is checked
    if (ctrl_i.walk) begin
      idx_d = idx_q + CW'(1);
      if ((idx_q != '0) && fire) fired_d[proc_idx] = 1'b1;
    end

    if (ctrl_i.scan) begin
      if (found) begin
        used_d[scan_idx] = 1'b1;
        count_d          = count_q + UCW'(1);
        taken_d          = scan_idx;
        status_d         = STATUS_OK;
      end else begin
        idx_d = idx_q + CW'(1);
      end
    end
  end

  always_comb begin
    out_d = out_q;
    if (ctrl_i.load_out) begin
      out_d.status       = status_q;
      out_d.slot_taken   = 5'(taken_q);
      out_d.fired_mask   = 32'(fired_q);
      out_d.tick_taken   = ticked_q;
      out_d.used_slots   = 6'(count_q);
      out_d.ticks_so_far = tick_total_q;
    end
    if (ctrl_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= TICK_PERIOD_RST;
      timer_on_q   <= 1'b0;
      compare_q    <= '0;
      tick_total_q <= '0;
      used_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      period_q     <= period_d;
      timer_on_q   <= timer_on_d;
      compare_q    <= compare_d;
      tick_total_q <= tick_total_d;
      used_q       <= used_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    taken_q  <= taken_d;
    fired_q  <= fired_d;
    ticked_q <= ticked_d;
    out_q    <= out_d;
  end

  assign stat_o.walk_start = (item_q.command == CMD_TICK) && tick_match;
  assign stat_o.scan_start = (item_q.command == CMD_REGISTER) && (item_q.amount != '0);
  assign stat_o.walk_done  = (idx_q == CW'(NUM_SLOTS));
  assign stat_o.scan_end   = (idx_q == CW'(NUM_SLOTS - 1));
  assign stat_o.found      = found;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/compare_tick_with_timer_slots.sv]
// Accepted items pass IDLE, EXEC and FIN; a register item with a nonzero interval
// also runs a lowest-free-slot scan (one slot a cycle), and a matching tick a walk
// over all slots through the due/interval RAM read ports.
// One item at a time: the next item is taken in the cycle after a result is loaded.
// Reset (async, active low): timer off, compare point and tick count zero, all slots
// free, tick period 1000000; slot RAMs are not cleared.
`default_nettype none

module compare_tick_with_timer_slots #(
  parameter int unsigned NUM_SLOTS = ctts_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ctts_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ctts_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [63:0]         cfg_wdata_i
);

  import ctts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ctts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ctts_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

[bench/timer_slot_checker.sv]
`default_nettype none

module timer_slot_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire ctts_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire ctts_pkg::out_item_t out_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [63:0]         cfg_wdata_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import ctts_pkg::*;

  localparam int NSLOT = NUM_SLOTS_DEF;

  // shadow copy of the timer state
  logic [63:0] period_q;
  logic        on_q;
  logic [63:0] cmp_q;
  logic [31:0] ticks_q;
  logic        used_q [NSLOT];
  logic [63:0] ival_q [NSLOT];
  logic [63:0] due_q  [NSLOT];
  logic [5:0]  cnt_q;

  out_item_t result_q [$];
  out_item_t want;
  int        fails;

  function automatic out_item_t timer_step(input in_item_t it);
    out_item_t r;
    int        i;
    bit        hit;
    r   = '0;
    hit = 1'b0;
    case (it.command)
      CMD_TICK: begin
        if (on_q && it.now >= cmp_q) begin
          ticks_q      = ticks_q + 32'd1;
          cmp_q        = it.now + period_q;
          r.tick_taken = 1'b1;
          for (i = 0; i < NSLOT; i++) begin
            if (used_q[i] && it.now >= due_q[i]) begin
              r.fired_mask[i] = 1'b1;
              due_q[i]        = it.now + ival_q[i];
            end
          end
        end
      end
      CMD_REGISTER: begin
        r.status = STATUS_REJECT;
        if (it.amount != 64'd0) begin
          for (i = 0; i < NSLOT; i++) begin
            if (!hit && !used_q[i]) begin
              hit          = 1'b1;
              used_q[i]    = 1'b1;
              ival_q[i]    = it.amount;
              due_q[i]     = it.now + it.amount;
              cnt_q        = cnt_q + 6'd1;
              r.slot_taken = i[4:0];
              r.status     = STATUS_OK;
            end
          end
        end
      end
      CMD_UNREGISTER: begin
        if (int'(it.slot_select) < NSLOT && used_q[it.slot_select]) begin
          used_q[it.slot_select] = 1'b0;
          ival_q[it.slot_select] = 64'd0;
          due_q[it.slot_select]  = 64'd0;
          cnt_q                  = cnt_q - 6'd1;
        end else begin
          r.status = STATUS_REJECT;
        end
      end
      CMD_SET_PERIODIC: begin
        if (it.amount == 64'd0) begin
          r.status = STATUS_REJECT;
        end else begin
          cmp_q = it.now + it.amount;
          on_q  = 1'b1;
        end
      end
      CMD_SET_ONESHOT: begin
        cmp_q = it.amount;
        on_q  = 1'b1;
      end
      CMD_ENABLE: begin
        on_q  = 1'b1;
        cmp_q = it.now + period_q;
      end
      CMD_DISABLE: begin
        on_q = 1'b0;
      end
      default: begin
        r.status = STATUS_REJECT;
      end
    endcase
    r.used_slots   = cnt_q;
    r.ticks_so_far = ticks_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q = TICK_PERIOD_RST;
      on_q     = 1'b0;
      cmp_q    = 64'd0;
      ticks_q  = 32'd0;
      cnt_q    = 6'd0;
      for (int i = 0; i < NSLOT; i++) begin
        used_q[i] = 1'b0;
        ival_q[i] = 64'd0;
        due_q[i]  = 64'd0;
      end
      result_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) period_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) result_q.push_back(timer_step(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result item with no input item outstanding");
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("slot_taken", want.slot_taken, out_data_i.slot_taken);
          check_field("fired_mask", want.fired_mask, out_data_i.fired_mask);
          check_field("tick_taken", want.tick_taken, out_data_i.tick_taken);
          check_field("used_slots", want.used_slots, out_data_i.used_slots);
          check_field("ticks_so_far", want.ticks_so_far, out_data_i.ticks_so_far);
        end
      end
      fail_count_o <= fails;
      pending_o    <= result_q.size();
    end
  end

endmodule

`default_nettype wire

[bench/compare_tick_with_timer_slots_tb.sv]
`default_nettype none

module compare_tick_with_timer_slots_tb;
  import ctts_pkg::*;

  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 80;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [63:0] cfg_wdata = 64'd0;

  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;
  int          fails;
  int          pending;

  bit          gaps_on  = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  logic [63:0] cur_now  = 64'd0;

  always #5 clk = ~clk;

  compare_tick_with_timer_slots i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  timer_slot_checker i_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t mk(input logic [2:0] cmd, input logic [63:0] now_v,
                                  input logic [63:0] amt, input logic [4:0] sel);
    in_item_t it;
    it.command     = cmd;
    it.now         = now_v;
    it.amount      = amt;
    it.slot_select = sel;
    return it;
  endfunction

  // mostly well-formed traffic around the current time, a little noise
  function automatic in_item_t rand_item(input logic [63:0] now_v, input int unsigned span,
                                         input int reg_w, input int unreg_w);
    in_item_t it;
    int       pick;
    int       lim;
    it   = mk(CMD_TICK, now_v, rand64(), 5'($urandom_range(31)));
    pick = $urandom_range(99);
    lim  = 5;
    if (pick < lim) begin
      it.command = 3'($urandom_range(7));
      it.now     = rand64();
    end else if (pick < lim + reg_w) begin
      it.command = CMD_REGISTER;
      case ($urandom_range(19))
        0:       it.amount = 64'd0;
        1:       it.amount = rand64();
        default: it.amount = 64'($urandom_range(4 * span, 1));
      endcase
    end else if (pick < lim + reg_w + unreg_w) begin
      it.command = CMD_UNREGISTER;
    end else if (pick < lim + reg_w + unreg_w + 4) begin
      it.command = CMD_SET_PERIODIC;
      it.amount  = ($urandom_range(7) == 0) ? 64'd0 : 64'($urandom_range(2 * span, 1));
    end else if (pick < lim + reg_w + unreg_w + 8) begin
      it.command = CMD_SET_ONESHOT;
      if ($urandom_range(7) != 0) it.amount = now_v + 64'($urandom_range(2 * span));
    end else if (pick < lim + reg_w + unreg_w + 14) begin
      it.command = CMD_ENABLE;
    end else if (pick < lim + reg_w + unreg_w + 17) begin
      it.command = CMD_DISABLE;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (gaps_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result item is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_period(input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !gaps_on || ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin
    #5000000;
    $display("compare_tick_with_timer_slots verification failed");
    $finish;
  end

  initial begin
    logic [63:0] periods [8];
    int unsigned spans   [8];
    logic [63:0] ones;
    int          reg_w;
    int          unreg_w;

    ones = '1;
    periods[0] = TICK_PERIOD_RST;  spans[0] = 1000000;
    periods[1] = 64'd1;            spans[1] = 8;
    periods[2] = 64'd37;           spans[2] = 64;
    periods[3] = 64'd0;            spans[3] = 4;
    periods[4] = ones;             spans[4] = 1000;
    periods[5] = 64'd500;          spans[5] = 800;
    periods[6] = 64'($urandom_range(1 << 20, 1));
    spans[6]   = 32'(periods[6]);
    periods[7] = rand64();         spans[7] = 4096;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, tick period at its reset value
    send_item(mk(CMD_TICK, 64'd0, 64'd0, 5'd0));          // timer off
    send_item(mk(CMD_DISABLE, 64'd0, 64'd0, 5'd0));       // already off
    send_item(mk(CMD_REGISTER, 64'd100, 64'd0, 5'd0));    // zero interval
    send_item(mk(CMD_REGISTER, 64'd100, 64'd1, 5'd0));
    send_item(mk(CMD_REGISTER, 64'd100, ones, 5'd0));     // due wraps
    send_item(mk(CMD_ENABLE, 64'd1000, 64'd0, 5'd0));
    send_item(mk(CMD_TICK, 64'd2000, 64'd0, 5'd0));       // before compare
    send_item(mk(CMD_TICK, 64'd1001000, 64'd0, 5'd0));    // exactly at compare
    send_item(mk(CMD_ENABLE, 64'd1001000, 64'd0, 5'd0));  // already on
    send_item(mk(CMD_SET_PERIODIC, 64'd1001000, 64'd0, 5'd0));
    send_item(mk(CMD_SET_PERIODIC, 64'd1001000, 64'd5, 5'd0));
    send_item(mk(CMD_DISABLE, 64'd1001001, 64'd0, 5'd0));
    send_item(mk(CMD_TICK, 64'd1001010, 64'd0, 5'd0));    // off again
    send_item(mk(CMD_SET_ONESHOT, 64'd1001001, 64'd0, 5'd0)); // turns on
    send_item(mk(CMD_TICK, 64'd1001001, 64'd0, 5'd0));
    send_item(mk(CMD_UNREGISTER, 64'd0, 64'd0, 5'd31));   // inactive slot
    send_item(mk(CMD_UNREGISTER, 64'd0, 64'd0, 5'd0));
    send_item(mk(CMD_UNKNOWN, ones, ones, 5'd31));
    send_item(mk(CMD_TICK, ones, ones, 5'd31));
    send_item(mk(CMD_ENABLE, ones, 64'd0, 5'd0));         // compare wraps
    send_item(mk(CMD_TICK, 64'd5, 64'd0, 5'd0));
    send_item(mk(CMD_SET_PERIODIC, 64'd10, ones, 5'd0));
    send_item(mk(CMD_TICK, 64'd10, 64'd0, 5'd0));
    send_item(mk(CMD_SET_ONESHOT, 64'd10, ones, 5'd0));
    send_item(mk(CMD_TICK, 64'd20, 64'd0, 5'd0));
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p != 0) write_period(periods[p]);
      if (p == 4) cur_now = 64'hFFFF_FFFF_FFF0_0000;
      if (p == 5) cur_now = rand64();
      gaps_on = (p != 2);
      if (p == 1) hold_req = 1'b1;
      // alternate between filling and draining the slot table
      reg_w   = (p % 2 == 0) ? 20 : 10;
      unreg_w = (p % 2 == 0) ? 10 : 25;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) settle();
        send_item(rand_item(cur_now, spans[p], reg_w, unreg_w));
        cur_now = cur_now + 64'($urandom_range(spans[p] / 2));
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("compare_tick_with_timer_slots verification clean");
    end else begin
      $display("compare_tick_with_timer_slots verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/ctts_pkg.sv
rtl/ctts_ram.sv
rtl/ctts_ctrl.sv
rtl/ctts_dp.sv
rtl/compare_tick_with_timer_slots.sv
bench/timer_slot_checker.sv
bench/compare_tick_with_timer_slots_tb.sv
